// ----- hdl/dpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for the depth pixel back-projection unit
// Item formats, register map, reset values, sampling grid bounds and the
// per-stage enable bundle passed to the projection lanes.
// ----------------------------------------------------------------------------
package dpb_pkg;

   // field widths
   localparam int ROW_W   = 10;
   localparam int COL_W   = 11;
   localparam int DEPTH_W = 16;
   localparam int COST_W  = 16;
   localparam int RECIP_W = 24;
   localparam int POINT_W = 16;

   // fraction bits of the reciprocal focal lengths
   localparam int FRAC_BITS = 24;

   // image bounds
   localparam int MAX_ROWS = 1024;
   localparam int MAX_COLS = 2048;

   // sampling grid: three row bands with column steps 3, 5 and 10
   localparam int BAND3_LO  = 240;
   localparam int BAND3_HI  = 279;
   localparam int BAND5_LO  = 282;
   localparam int BAND5_HI  = 317;
   localparam int BAND10_LO = 322;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_FAR     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_NEAR    = 3'd5;

   // register reset values
   localparam logic [COL_W-1:0]   RST_CENTER_X  = 11'd423;
   localparam logic [ROW_W-1:0]   RST_CENTER_Y  = 10'd239;
   localparam logic [RECIP_W-1:0] RST_RECIP_FX  = 24'd39476;
   localparam logic [RECIP_W-1:0] RST_RECIP_FY  = 24'd39476;
   localparam logic [DEPTH_W-1:0] RST_DEPTH_FAR = 16'd6000;
   localparam logic [DEPTH_W-1:0] RST_DEPTH_NEAR = 16'd100;

   typedef struct packed {
      logic [ROW_W-1:0]   pixel_row;
      logic [COL_W-1:0]   pixel_col;
      logic [DEPTH_W-1:0] depth_mm;
      logic [COST_W-1:0]  cost_level;
   } dpb_req_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x_mm;
      logic signed [POINT_W-1:0] point_y_mm;
      logic [DEPTH_W-1:0]        point_z_mm;
   } dpb_rsp_type;

   // load enables for pipeline stages 2..5
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
      logic en5;
   } dpb_stage_en_type;

endpackage

// ----- hdl/dpb_proj_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_proj_lane: one axis of the pinhole back-projection
// Computes floor((coord - center) * depth * recip / 2^24) saturated to int16
// over four register stages: offset, depth product, reciprocal product,
// round and saturate.
// ----------------------------------------------------------------------------
module dpb_proj_lane #(
   parameter int COORD_W = 11
) (
   input  logic                                clock,
   input  dpb_pkg::dpb_stage_en_type           stage_en,
   input  logic [COORD_W-1:0]                  coord,
   input  logic [COORD_W-1:0]                  center,
   input  logic [dpb_pkg::DEPTH_W-1:0]         depth,
   input  logic [dpb_pkg::RECIP_W-1:0]         recip,
   output logic signed [dpb_pkg::POINT_W-1:0]  result
);
   import dpb_pkg::*;

   localparam int PROD_W = COORD_W + DEPTH_W;
   localparam int MAG_W  = PROD_W + RECIP_W;
   localparam int QUO_W  = MAG_W - FRAC_BITS + 1;

   localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
   localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);

   logic                      neg_in;
   logic [COORD_W-1:0]        diff_in;
   logic                      neg2_ff, neg3_ff, neg4_ff;
   logic [COORD_W-1:0]        diff2_ff;
   logic [PROD_W-1:0]         prod3_ff;
   logic [MAG_W-1:0]          mag4_ff;
   logic [QUO_W-1:0]          quo;
   logic signed [POINT_W-1:0] result_in;
   logic signed [POINT_W-1:0] result_ff;

   // offset from principal point as sign and magnitude
   assign neg_in  = coord < center;
   assign diff_in = neg_in ? center - coord : coord - center;

   // stage 2: offset
   always_ff @(posedge clock) begin
      if (stage_en.en2) begin
         neg2_ff  <= neg_in;
         diff2_ff <= diff_in;
      end
   end

   // stage 3: offset times depth
   always_ff @(posedge clock) begin
      if (stage_en.en3) begin
         neg3_ff  <= neg2_ff;
         prod3_ff <= PROD_W'(diff2_ff) * PROD_W'(depth);
      end
   end

   // stage 4: times reciprocal focal length
   always_ff @(posedge clock) begin
      if (stage_en.en4) begin
         neg4_ff <= neg3_ff;
         mag4_ff <= MAG_W'(prod3_ff) * MAG_W'(recip);
      end
   end

   // floor toward minus infinity: negative magnitudes round up
   assign quo = QUO_W'(mag4_ff[MAG_W-1:FRAC_BITS])
              + QUO_W'(neg4_ff && (|mag4_ff[FRAC_BITS-1:0]));

   always_comb begin
      if (neg4_ff) begin
         if (quo > NEG_LIMIT) begin
            result_in = signed'(POINT_W'(NEG_LIMIT));
         end else begin
            result_in = signed'(POINT_W'(QUO_W'(0) - quo));
         end
      end else begin
         if (quo > POS_LIMIT) begin
            result_in = signed'(POINT_W'(POS_LIMIT));
         end else begin
            result_in = signed'(quo[POINT_W-1:0]);
         end
      end
   end

   // stage 5: saturated result
   always_ff @(posedge clock) begin
      if (stage_en.en5) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hdl/depth_pixel_backprojection_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit: depth pixel to 3-D point converter
// Accepts one pixel item per clock unless req_stall is raised, and emits a
// point for every pixel that lies on the sampling grid and passes the depth
// and cost checks. An accepted pixel is carried through five register stages
// in order: input capture, grid check with offset, depth multiply, reciprocal
// multiply and saturation; the point is shown on rsp from the last of them, and
// dropped pixels leave a bubble. A stalled output backs up stage by stage, so
// bubbles are squeezed out before the input is stalled.
// Configuration registers may be written only when no item is in flight.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit (
   input  logic                          clock,
   input  logic                          reset,
   // pixel items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dpb_pkg::dpb_req_type          req_payload,
   // point items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dpb_pkg::dpb_rsp_type          rsp_payload,
   // register writes
   input  logic                          csr_wr_en,
   input  logic [dpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpb_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import dpb_pkg::*;

   // reciprocal multipliers for exact small-constant division of 11-bit values
   localparam int           REC_W   = 16;
   localparam int           MUL_W   = COL_W + REC_W;
   localparam logic [REC_W-1:0] REC3  = 16'd43691; // 2^17 / 3
   localparam logic [REC_W-1:0] REC5  = 16'd52429; // 2^18 / 5, and 2^19 / 10
   localparam int           SHIFT3  = 17;
   localparam int           SHIFT5  = 18;
   localparam int           SHIFT10 = 19;

   // configuration registers
   logic [COL_W-1:0]   center_x_ff;
   logic [ROW_W-1:0]   center_y_ff;
   logic [RECIP_W-1:0] recip_fx_ff;
   logic [RECIP_W-1:0] recip_fy_ff;
   logic [DEPTH_W-1:0] depth_far_ff;
   logic [DEPTH_W-1:0] depth_near_ff;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   dpb_stage_en_type stage_en;

   // stage payloads
   dpb_req_type        req1_ff;
   logic [DEPTH_W-1:0] depth2_ff, depth3_ff, depth4_ff, depth5_ff;

   // grid and range checks
   logic [COL_W-1:0] row_wide;
   logic [COL_W-1:0] off3, off5, off10;
   logic             row_ok, col_ok;
   logic             in_band3, in_band5, in_band10;
   logic             on_grid, depth_ok, keep1;

   logic signed [POINT_W-1:0] point_x, point_y;

   function automatic logic mult_of_3(input logic [COL_W-1:0] v);
      logic [MUL_W-1:0] p;
      logic [COL_W-1:0] q;
      p = MUL_W'(v) * MUL_W'(REC3);
      q = COL_W'(p >> SHIFT3);
      return (COL_W + 2)'(q) * (COL_W + 2)'(3) == (COL_W + 2)'(v);
   endfunction

   function automatic logic mult_of_5(input logic [COL_W-1:0] v);
      logic [MUL_W-1:0] p;
      logic [COL_W-1:0] q;
      p = MUL_W'(v) * MUL_W'(REC5);
      q = COL_W'(p >> SHIFT5);
      return (COL_W + 3)'(q) * (COL_W + 3)'(5) == (COL_W + 3)'(v);
   endfunction

   function automatic logic mult_of_10(input logic [COL_W-1:0] v);
      logic [MUL_W-1:0] p;
      logic [COL_W-1:0] q;
      p = MUL_W'(v) * MUL_W'(REC5);
      q = COL_W'(p >> SHIFT10);
      return (COL_W + 4)'(q) * (COL_W + 4)'(10) == (COL_W + 4)'(v);
   endfunction

   // register writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= RST_CENTER_X;
         center_y_ff   <= RST_CENTER_Y;
         recip_fx_ff   <= RST_RECIP_FX;
         recip_fy_ff   <= RST_RECIP_FY;
         depth_far_ff  <= RST_DEPTH_FAR;
         depth_near_ff <= RST_DEPTH_NEAR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CENTER_X:      center_x_ff   <= csr_wr_data[COL_W-1:0];
            CSR_CENTER_Y:      center_y_ff   <= csr_wr_data[ROW_W-1:0];
            CSR_RECIP_FOCAL_X: recip_fx_ff   <= csr_wr_data[RECIP_W-1:0];
            CSR_RECIP_FOCAL_Y: recip_fy_ff   <= csr_wr_data[RECIP_W-1:0];
            CSR_DEPTH_FAR:     depth_far_ff  <= csr_wr_data[DEPTH_W-1:0];
            CSR_DEPTH_NEAR:    depth_near_ff <= csr_wr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // ready chain: a stage loads when it is empty or its successor loads
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   assign stage_en.en2 = rdy2;
   assign stage_en.en3 = rdy3;
   assign stage_en.en4 = rdy4;
   assign stage_en.en5 = rdy5;

   // stage 1: capture the pixel
   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         req1_ff <= req_payload;
      end
   end

   // sampling grid decode
   assign row_wide = COL_W'(req1_ff.pixel_row);
   assign off3     = row_wide - COL_W'(BAND3_LO);
   assign off5     = row_wide - COL_W'(BAND5_LO);
   assign off10    = row_wide - COL_W'(BAND10_LO);

   assign row_ok    = int'(req1_ff.pixel_row) < MAX_ROWS;
   assign col_ok    = int'(req1_ff.pixel_col) < MAX_COLS;
   assign in_band3  = row_wide >= COL_W'(BAND3_LO) && row_wide <= COL_W'(BAND3_HI);
   assign in_band5  = row_wide >= COL_W'(BAND5_LO) && row_wide <= COL_W'(BAND5_HI);
   assign in_band10 = row_wide >= COL_W'(BAND10_LO);

   assign on_grid = row_ok && col_ok && (
        (in_band3  && mult_of_3(off3)   && mult_of_3(req1_ff.pixel_col))
     || (in_band5  && mult_of_5(off5)   && mult_of_5(req1_ff.pixel_col))
     || (in_band10 && mult_of_10(off10) && mult_of_10(req1_ff.pixel_col)));

   assign depth_ok = req1_ff.depth_mm <= depth_far_ff
                  && req1_ff.depth_mm >= depth_near_ff
                  && req1_ff.cost_level != '0;

   assign keep1 = on_grid && depth_ok;

   // valid bits; dropped pixels become bubbles at stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff && keep1;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // depth travels alongside the lanes as the z coordinate
   always_ff @(posedge clock) begin
      if (rdy2) depth2_ff <= req1_ff.depth_mm;
      if (rdy3) depth3_ff <= depth2_ff;
      if (rdy4) depth4_ff <= depth3_ff;
      if (rdy5) depth5_ff <= depth4_ff;
   end

   // x and y projection lanes
   dpb_proj_lane #(
      .COORD_W (COL_W)
   ) u_lane_x (
      .clock    (clock),
      .stage_en (stage_en),
      .coord    (req1_ff.pixel_col),
      .center   (center_x_ff),
      .depth    (depth2_ff),
      .recip    (recip_fx_ff),
      .result   (point_x)
   );

   dpb_proj_lane #(
      .COORD_W (ROW_W)
   ) u_lane_y (
      .clock    (clock),
      .stage_en (stage_en),
      .coord    (req1_ff.pixel_row),
      .center   (center_y_ff),
      .depth    (depth2_ff),
      .recip    (recip_fy_ff),
      .result   (point_y)
   );

   // output
   assign rsp_valid              = v5_ff;
   assign rsp_payload.point_x_mm = point_x;
   assign rsp_payload.point_y_mm = point_y;
   assign rsp_payload.point_z_mm = depth5_ff;

endmodule

// ----- hdl/dpb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_port_checker: port-level checks for the back-projection unit
// Watches the item channels and flags handshake, reset and arithmetic slips.
// ----------------------------------------------------------------------------
module dpb_port_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input dpb_pkg::dpb_rsp_type rsp_payload
);
   import dpb_pkg::*;

   // a stalled output item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("output item changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output item present after reset");

   // input stalls only when the pipeline is full behind a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled output item");

   // zero depth projects to the origin
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.point_z_mm == '0
         |-> rsp_payload.point_x_mm == '0 && rsp_payload.point_y_mm == '0)
      else $error("nonzero lateral coordinate at zero depth");

endmodule

bind depth_pixel_backprojection_unit dpb_port_checker u_dpb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- tb/dpb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_checker: point predictor and scoreboard for the back-projection unit
// Watches the register port, the pixel channel and the point channel. Each
// accepted pixel on the sampling grid that passes the depth window and the
// cost check queues one predicted point; each accepted point is compared,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dpb_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  dpb_pkg::dpb_req_type           req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  dpb_pkg::dpb_rsp_type           rsp_payload,
   input  logic                           csr_wr_en,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpb_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             error_count,
   output int                             points_due,
   output int                             points_checked
);
   import dpb_pkg::*;

   // keep the log readable when the design is badly broken
   localparam int REPORT_LIMIT = 40;

   // shadow copy of the camera registers
   logic [COL_W-1:0]   cam_center_x;
   logic [ROW_W-1:0]   cam_center_y;
   logic [RECIP_W-1:0] cam_recip_fx;
   logic [RECIP_W-1:0] cam_recip_fy;
   logic [DEPTH_W-1:0] window_far;
   logic [DEPTH_W-1:0] window_near;

   dpb_rsp_type predicted_points[$];

   // column step of a sampled row, 0 for rows off the grid
   function automatic int unsigned grid_step(input logic [ROW_W-1:0] row);
      int r;
      r = int'(row);
      if (r >= BAND3_LO && r <= BAND3_HI) return ((r - BAND3_LO) % 3 == 0) ? 3 : 0;
      if (r >= BAND5_LO && r <= BAND5_HI) return ((r - BAND5_LO) % 5 == 0) ? 5 : 0;
      if (r >= BAND10_LO && r < MAX_ROWS) return ((r - BAND10_LO) % 10 == 0) ? 10 : 0;
      return 0;
   endfunction

   // floor((coord - center) * depth * recip / 2^24), clamped to 16 bits signed
   function automatic logic signed [POINT_W-1:0] project_axis(
      input int                 coord,
      input int                 center,
      input logic [DEPTH_W-1:0] depth,
      input logic [RECIP_W-1:0] recip
   );
      longint prod;
      longint q;
      prod = longint'(coord - center) * longint'(depth) * longint'(recip);
      q = prod >>> FRAC_BITS;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[POINT_W-1:0];
   endfunction

   task automatic flag_field(input string what, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : track_points
      dpb_rsp_type want;
      dpb_rsp_type got;
      int unsigned step;
      if (reset) begin
         cam_center_x = RST_CENTER_X;
         cam_center_y = RST_CENTER_Y;
         cam_recip_fx = RST_RECIP_FX;
         cam_recip_fy = RST_RECIP_FY;
         window_far   = RST_DEPTH_FAR;
         window_near  = RST_DEPTH_NEAR;
         predicted_points.delete();
      end else begin
         // register writes, masked to register width; spare indexes do nothing
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTER_X:      cam_center_x = csr_wr_data[COL_W-1:0];
               CSR_CENTER_Y:      cam_center_y = csr_wr_data[ROW_W-1:0];
               CSR_RECIP_FOCAL_X: cam_recip_fx = csr_wr_data[RECIP_W-1:0];
               CSR_RECIP_FOCAL_Y: cam_recip_fy = csr_wr_data[RECIP_W-1:0];
               CSR_DEPTH_FAR:     window_far   = csr_wr_data[DEPTH_W-1:0];
               CSR_DEPTH_NEAR:    window_near  = csr_wr_data[DEPTH_W-1:0];
               default: ;
            endcase
         end

         // predict a point for each accepted pixel that survives the filters
         if (req_valid && !req_stall) begin
            step = grid_step(req_payload.pixel_row);
            if (step != 0 && int'(req_payload.pixel_col) % step == 0 &&
                req_payload.depth_mm <= window_far &&
                req_payload.depth_mm >= window_near &&
                req_payload.cost_level != '0) begin
               want.point_x_mm = project_axis(int'(req_payload.pixel_col),
                  int'(cam_center_x), req_payload.depth_mm, cam_recip_fx);
               want.point_y_mm = project_axis(int'(req_payload.pixel_row),
                  int'(cam_center_y), req_payload.depth_mm, cam_recip_fy);
               want.point_z_mm = req_payload.depth_mm;
               predicted_points.push_back(want);
            end
         end

         // compare each accepted point with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (predicted_points.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: point mismatch, expected nothing, actual (%0d, %0d, %0d)",
                     $time, got.point_x_mm, got.point_y_mm, got.point_z_mm);
            end else begin
               want = predicted_points.pop_front();
               points_checked++;
               if (got.point_x_mm !== want.point_x_mm)
                  flag_field("point_x_mm", int'(want.point_x_mm), int'(got.point_x_mm));
               if (got.point_y_mm !== want.point_y_mm)
                  flag_field("point_y_mm", int'(want.point_y_mm), int'(got.point_y_mm));
               if (got.point_z_mm !== want.point_z_mm)
                  flag_field("point_z_mm", int'(want.point_z_mm), int'(got.point_z_mm));
            end
         end
      end
      points_due = predicted_points.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the depth pixel back-projection unit
// Drives pixel items through a series of camera settings (reset values,
// saturating extremes, a collapsed depth window, an empty window and random
// settings), idles both channels at random, forces a long output hold-off
// that fills the pipeline, and lets dpb_checker score every point.
// ----------------------------------------------------------------------------
module testbench;
   import dpb_pkg::*;

   // indexes past the register map; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int MAX_GAP      = 17;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [COL_W-1:0]   center_x;
      logic [ROW_W-1:0]   center_y;
      logic [RECIP_W-1:0] recip_fx;
      logic [RECIP_W-1:0] recip_fy;
      logic [DEPTH_W-1:0] depth_far;
      logic [DEPTH_W-1:0] depth_near;
   } cam_setting_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   dpb_req_type           req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   dpb_rsp_type           rsp_payload;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int error_count;
   int points_due;
   int points_checked;

   cam_setting_type cur;
   int  pixels_sent;
   int  settings_used;
   bit  sender_quiet;
   bit  receiver_quiet;
   bit  long_hold_req;

   depth_pixel_backprojection_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dpb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .error_count    (error_count),
      .points_due     (points_due),
      .points_checked (points_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic cam_setting_type make_setting(
      input int cx, input int cy, input int rfx, input int rfy, input int far, input int near
   );
      cam_setting_type s;
      s.center_x   = COL_W'(cx);
      s.center_y   = ROW_W'(cy);
      s.recip_fx   = RECIP_W'(rfx);
      s.recip_fy   = RECIP_W'(rfy);
      s.depth_far  = DEPTH_W'(far);
      s.depth_near = DEPTH_W'(near);
      return s;
   endfunction

   // mostly realistic focal lengths, sometimes anything in the register
   function automatic cam_setting_type random_setting();
      int near;
      int rfx;
      int rfy;
      near = $urandom_range(0, 3000);
      rfx = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 1 << 18);
      rfy = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 1 << 18);
      return make_setting($urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
                          rfx, rfy, $urandom_range(near, 65535), near);
   endfunction

   function automatic dpb_req_type pix(input int row, input int col, input int depth,
                                       input int cost);
      dpb_req_type p;
      p.pixel_row  = ROW_W'(row);
      p.pixel_col  = COL_W'(col);
      p.depth_mm   = DEPTH_W'(depth);
      p.cost_level = COST_W'(cost);
      return p;
   endfunction

   // Well-formed pixels land on the grid inside the depth window; a slice of
   // them probes the window edges and zero cost. The rest is raw noise.
   function automatic dpb_req_type random_pixel(input bit force_point);
      dpb_req_type p;
      int unsigned pick;
      int unsigned step;
      pick = force_point ? 50 : $urandom_range(0, 99);
      if (pick >= 75) begin
         p.pixel_row  = ROW_W'($urandom);
         p.pixel_col  = COL_W'($urandom);
         p.depth_mm   = DEPTH_W'($urandom);
         p.cost_level = COST_W'($urandom);
         return p;
      end
      case ($urandom_range(0, 2))
         0: begin
            step = 3;
            p.pixel_row = ROW_W'(BAND3_LO + 3 * $urandom_range(0, (BAND3_HI - BAND3_LO) / 3));
         end
         1: begin
            step = 5;
            p.pixel_row = ROW_W'(BAND5_LO + 5 * $urandom_range(0, (BAND5_HI - BAND5_LO) / 5));
         end
         default: begin
            step = 10;
            p.pixel_row =
               ROW_W'(BAND10_LO + 10 * $urandom_range(0, (MAX_ROWS - 1 - BAND10_LO) / 10));
         end
      endcase
      p.pixel_col  = COL_W'(step * $urandom_range(0, (MAX_COLS - 1) / step));
      p.cost_level = COST_W'($urandom_range(1, 65535));
      if (cur.depth_near <= cur.depth_far)
         p.depth_mm = DEPTH_W'($urandom_range(cur.depth_near, cur.depth_far));
      else
         p.depth_mm = DEPTH_W'($urandom);
      if (pick < 5) begin
         p.cost_level = '0;
      end else if (pick < 10) begin
         p.depth_mm = pick[0] ? cur.depth_near : cur.depth_far;
      end else if (pick < 15) begin
         // one step outside the window
         if (cur.depth_near != '0) p.depth_mm = cur.depth_near - 1'b1;
         else if (cur.depth_far != '1) p.depth_mm = cur.depth_far + 1'b1;
      end
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] v,
                                                       input int w);
      logic [CSR_DATA_W-1:0] keep;
      keep = (CSR_DATA_W'(1) << w) - 1'b1;
      return (CSR_DATA_W'($urandom) & ~keep) | (v & keep);
   endfunction

   // leaves the write enable high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   // stop sending, wait for every predicted point, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock iff points_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input cam_setting_type s);
      drain();
      write_reg(CSR_CENTER_X,      with_junk(s.center_x, COL_W));
      write_reg(CSR_CENTER_Y,      with_junk(s.center_y, ROW_W));
      write_reg(CSR_RECIP_FOCAL_X, with_junk(s.recip_fx, RECIP_W));
      write_reg(CSR_RECIP_FOCAL_Y, with_junk(s.recip_fy, RECIP_W));
      write_reg(CSR_DEPTH_FAR,     with_junk(s.depth_far, DEPTH_W));
      write_reg(CSR_DEPTH_NEAR,    with_junk(s.depth_near, DEPTH_W));
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cur = s;
      settings_used++;
   endtask

   task automatic send_pixel(input dpb_req_type p);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock iff !req_stall);
      pixels_sent++;
   endtask

   // point receiver: random hold before each item, or one long hold on request
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else begin
            hold = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff (rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_CENTER_X;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      cur = make_setting(RST_CENTER_X, RST_CENTER_Y, RST_RECIP_FX, RST_RECIP_FY,
                         RST_DEPTH_FAR, RST_DEPTH_NEAR);
      settings_used = 1;

      // reset values: grid corners, window edges, zero cost, off-grid rows and columns
      send_pixel(pix(240, 0, 100, 1));
      send_pixel(pix(240, 420, 100, 7));      // small negative, rounds down to -1
      send_pixel(pix(240, 423, 3000, 9));     // on the principal column
      send_pixel(pix(279, 2046, 6000, 65535));
      send_pixel(pix(282, 2045, 5000, 3));
      send_pixel(pix(317, 5, 1234, 3));
      send_pixel(pix(322, 2040, 6000, 1));
      send_pixel(pix(1022, 0, 4000, 1));
      send_pixel(pix(240, 3, 99, 1));
      send_pixel(pix(240, 3, 6001, 1));
      send_pixel(pix(240, 3, 500, 0));
      send_pixel(pix(240, 0, 65535, 65535));
      send_pixel(pix(0, 0, 500, 1));
      send_pixel(pix(239, 0, 500, 1));
      send_pixel(pix(241, 0, 500, 1));
      send_pixel(pix(280, 0, 500, 1));
      send_pixel(pix(281, 0, 500, 1));
      send_pixel(pix(318, 0, 500, 1));
      send_pixel(pix(321, 0, 500, 1));
      send_pixel(pix(323, 0, 500, 1));
      send_pixel(pix(1023, 0, 500, 1));
      send_pixel(pix(240, 1, 500, 1));
      send_pixel(pix(282, 3, 500, 1));
      send_pixel(pix(322, 5, 500, 1));

      // largest gains from the image origin: positive saturation
      load_settings(make_setting(0, 0, 24'hFFFFFF, 24'hFFFFFF, 65535, 0));
      send_pixel(pix(240, 2046, 65535, 1));
      send_pixel(pix(1022, 0, 65535, 65535));
      send_pixel(pix(240, 3, 1, 1));
      send_pixel(pix(240, 0, 0, 1));
      repeat (100) send_pixel(random_pixel(1'b0));

      // principal point at the far corner: negative saturation
      load_settings(make_setting(MAX_COLS - 1, MAX_ROWS - 1, 24'hFFFFFF, 24'hFFFFFF, 65535, 0));
      send_pixel(pix(240, 0, 65535, 1));
      send_pixel(pix(240, 2046, 1, 1));
      repeat (100) send_pixel(random_pixel(1'b0));

      // zero gains and a window that admits depth zero only
      load_settings(make_setting(1000, 500, 0, 0, 0, 0));
      send_pixel(pix(240, 0, 0, 1));
      send_pixel(pix(240, 0, 1, 1));
      repeat (40) send_pixel(random_pixel(1'b0));

      // near limit above far limit: nothing gets through
      load_settings(make_setting(423, 239, 39476, 39476, 0, 65535));
      repeat (30) send_pixel(random_pixel(1'b0));

      // output held off while pixels keep coming back to back
      load_settings(random_setting());
      sender_quiet  = 1'b1;
      long_hold_req = 1'b1;
      repeat (40) send_pixel(random_pixel(1'b1));
      sender_quiet = 1'b0;

      // random settings with different idling mixes
      for (int ph = 0; ph < 4; ph++) begin
         sender_quiet   = (ph == 1) || (ph == 3);
         receiver_quiet = (ph == 2) || (ph == 3);
         load_settings(random_setting());
         repeat (120) send_pixel(random_pixel(1'b0));
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;

      drain();
      $display("Sent %0d pixels under %0d register settings; %0d points compared.",
               pixels_sent, settings_used, points_checked);
      $display("Covered grid bands and gaps, depth window edges, zero cost, both saturations.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
